[hw/rtl/crc16_packet_deframer_defines.svh]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_DEFRAMER_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_DEFINES_SVH

// Check that a property holds at every clock edge out of reset.
`define CPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs out of reset.
`define CPD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer package
// Shared constants, interface structs and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

  // Default payload buffer depth per slot
  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned REG_W   = 2;
  localparam int unsigned MAX_OUT = 64;

  // Framing bytes
  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFA;
  localparam logic [BYTE_W-1:0] TYPE_RAW_BYTE = 8'h10;
  localparam logic [BYTE_W-1:0] TYPE_NAV_BYTE = 8'h20;
  localparam logic [BYTE_W-1:0] TYPE_ACK_BYTE = 8'h80;

  // Packet type codes on the result side
  localparam logic [TYPE_W-1:0] PKT_RAW = 2'd0;
  localparam logic [TYPE_W-1:0] PKT_NAV = 2'd1;
  localparam logic [TYPE_W-1:0] PKT_ACK = 2'd2;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_RAW_LEN = 2'd0;
  localparam logic [REG_W-1:0] REG_NAV_LEN = 2'd1;
  localparam logic [REG_W-1:0] REG_ACK_LEN = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0] RAW_LEN_RST = 7'd16;
  localparam logic [LEN_W-1:0] NAV_LEN_RST = 7'd10;
  localparam logic [LEN_W-1:0] ACK_LEN_RST = 7'd12;

  // CRC-16/CCITT-FALSE
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // One good packet waiting for replay
  typedef struct packed {
    logic              slot;
    logic [TYPE_W-1:0] ptype;
    logic [LEN_W-1:0]  len;
  } desc_t;

  // Slot handed back by the replay side
  typedef struct packed {
    logic valid;
    logic slot;
  } release_t;

  // Fold one byte into the running CRC, MSB first
  function automatic logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] crc,
                                                  logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cpd_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the array, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cpd_front.sv]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer front end
// Parses the byte stream, stores payload into a free buffer slot, checks the
// CRC and posts good packets to the replay queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_deframer_defines.svh"

module cpd_front #(
  parameter int unsigned PAYLOAD_DEPTH = cpd_pkg::PAYLOAD_DEPTH_DEF,
  localparam int unsigned IDX_W        = $clog2(PAYLOAD_DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [cpd_pkg::REG_W-1:0]     cfg_idx_i,
  input  wire logic [cpd_pkg::LEN_W-1:0]     cfg_wdata_i,
  // byte stream
  input  wire logic                          push_i,
  input  wire logic [cpd_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                               full_o,
  // payload store write
  output logic                               we_o,
  output logic [IDX_W:0]                     waddr_o,
  output logic [cpd_pkg::BYTE_W-1:0]         wdata_o,
  // replay queue
  output logic                               desc_push_o,
  output cpd_pkg::desc_t                     desc_o,
  input  wire cpd_pkg::release_t             release_i
);

  localparam int unsigned CAP = (PAYLOAD_DEPTH < cpd_pkg::MAX_OUT) ?
                                PAYLOAD_DEPTH : cpd_pkg::MAX_OUT;
  localparam logic [cpd_pkg::LEN_W-1:0] CAP_LEN = cpd_pkg::LEN_W'(CAP);
  localparam logic [cpd_pkg::LEN_W-1:0] ONE_LEN = cpd_pkg::LEN_W'(1);

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_TYPE  = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_CRCLO = 5'b01000,
    ST_CRCHI = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [cpd_pkg::TYPE_W-1:0]     type_q, type_d;
  logic [cpd_pkg::LEN_W-1:0]      cnt_q, cnt_d;
  logic [cpd_pkg::LEN_W-1:0]      len_q, len_d;
  logic [cpd_pkg::CRC_W-1:0]      crc_q, crc_d;
  logic [cpd_pkg::BYTE_W-1:0]     crc_lo_q, crc_lo_d;
  logic                           ws_q, ws_d;
  logic [1:0]                     busy_q, busy_d;
  logic [cpd_pkg::LEN_W-1:0]      raw_len_q, nav_len_q, ack_len_q;

  logic                           accept;
  logic                           type_ok;
  logic [cpd_pkg::LEN_W-1:0]      sel_len;
  logic [cpd_pkg::LEN_W-1:0]      clamp_len;
  logic [cpd_pkg::LEN_W+IDX_W-1:0] cnt_ext;
  logic                           crc_good;

  // Hold off payload bytes while the target slot still holds a packet for replay
  assign full_o = (state_q == ST_DATA) && busy_q[ws_q];
  assign accept = push_i && !full_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q <= cpd_pkg::RAW_LEN_RST;
      nav_len_q <= cpd_pkg::NAV_LEN_RST;
      ack_len_q <= cpd_pkg::ACK_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpd_pkg::REG_RAW_LEN: raw_len_q <= cfg_wdata_i;
        cpd_pkg::REG_NAV_LEN: nav_len_q <= cfg_wdata_i;
        cpd_pkg::REG_ACK_LEN: ack_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Decode the type byte and pick its length
  always_comb begin
    type_ok = 1'b1;
    type_d  = type_q;
    sel_len = raw_len_q;
    case (rx_byte_i)
      cpd_pkg::TYPE_RAW_BYTE: begin
        type_d  = cpd_pkg::PKT_RAW;
        sel_len = raw_len_q;
      end
      cpd_pkg::TYPE_NAV_BYTE: begin
        type_d  = cpd_pkg::PKT_NAV;
        sel_len = nav_len_q;
      end
      cpd_pkg::TYPE_ACK_BYTE: begin
        type_d  = cpd_pkg::PKT_ACK;
        sel_len = ack_len_q;
      end
      default: type_ok = 1'b0;
    endcase
  end

  // Saturate the length into one slot
  always_comb begin
    if (sel_len == '0) begin
      clamp_len = ONE_LEN;
    end else if (sel_len > CAP_LEN) begin
      clamp_len = CAP_LEN;
    end else begin
      clamp_len = sel_len;
    end
  end

  assign crc_good = ({rx_byte_i, crc_lo_q} == crc_q);

  // Payload store write port
  assign cnt_ext = {{IDX_W{1'b0}}, cnt_q};
  assign we_o    = accept && (state_q == ST_DATA);
  assign waddr_o = {ws_q, cnt_ext[IDX_W-1:0]};
  assign wdata_o = rx_byte_i;

  // Queue entry for a good packet
  assign desc_push_o = accept && (state_q == ST_CRCHI) && crc_good;
  assign desc_o      = '{slot: ws_q, ptype: type_q, len: len_q};

  // Advance the parser
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    ws_d     = ws_q;
    if (accept) begin
      case (state_q)
        ST_HUNT: begin
          if (rx_byte_i == cpd_pkg::SYNC_BYTE) begin
            state_d = ST_TYPE;
          end
        end
        ST_TYPE: begin
          if (type_ok) begin
            len_d   = clamp_len;
            cnt_d   = '0;
            crc_d   = cpd_pkg::CRC_INIT;
            state_d = ST_DATA;
          end else begin
            state_d = ST_HUNT;
          end
        end
        ST_DATA: begin
          crc_d = cpd_pkg::crc_update(crc_q, rx_byte_i);
          cnt_d = cnt_q + ONE_LEN;
          if (cnt_d >= len_q) begin
            state_d = ST_CRCLO;
          end
        end
        ST_CRCLO: begin
          crc_lo_d = rx_byte_i;
          state_d  = ST_CRCHI;
        end
        ST_CRCHI: begin
          state_d = ST_HUNT;
          if (crc_good) begin
            ws_d = ~ws_q;
          end
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // Track slot ownership
  always_comb begin
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.slot] = 1'b0;
    end
    if (desc_push_o) begin
      busy_d[ws_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      type_q   <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      crc_q    <= cpd_pkg::CRC_INIT;
      crc_lo_q <= '0;
      ws_q     <= 1'b0;
      busy_q   <= '0;
    end else begin
      state_q  <= state_d;
      if (accept && (state_q == ST_TYPE) && type_ok) begin
        type_q <= type_d;
      end
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      ws_q     <= ws_d;
      busy_q   <= busy_d;
    end
  end

  `CPD_ASSERT_NEVER(a_write_busy_slot, we_o && busy_q[ws_q], "payload write into busy slot")
  `CPD_ASSERT_NEVER(a_release_free_slot, release_i.valid && !busy_q[release_i.slot],
                    "release of a slot that is not busy")

endmodule

`default_nettype wire

[hw/rtl/cpd_desc_fifo.sv]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer replay queue
// Two-entry queue of good-packet descriptors between parser and replay.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_deframer_defines.svh"

module cpd_desc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cpd_pkg::desc_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output cpd_pkg::desc_t      data_o,
  output logic                empty_o
);

  cpd_pkg::desc_t entry_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `CPD_ASSERT_NEVER(a_push_full, push_i && full_o, "descriptor pushed into full queue")
  `CPD_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "descriptor popped from empty queue")

endmodule

`default_nettype wire

[hw/rtl/cpd_back.sv]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer replay side
// Takes good-packet descriptors and reads their payload out of the slot,
// one byte per cycle into the result register while it is free or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_deframer_defines.svh"

module cpd_back #(
  parameter int unsigned PAYLOAD_DEPTH = cpd_pkg::PAYLOAD_DEPTH_DEF,
  localparam int unsigned IDX_W        = $clog2(PAYLOAD_DEPTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // replay queue
  input  wire logic                       desc_empty_i,
  input  wire cpd_pkg::desc_t             desc_i,
  output logic                            desc_pop_o,
  output cpd_pkg::release_t               release_o,
  // payload store read
  output logic                            re_o,
  output logic [IDX_W:0]                  raddr_o,
  // result side (payload byte comes from the RAM read register)
  input  wire logic                       pop_i,
  output logic                            empty_o,
  output logic [cpd_pkg::TYPE_W-1:0]      packet_type_o,
  output logic [cpd_pkg::INDEX_W-1:0]     byte_index_o,
  output logic                            last_o
);

  localparam logic [cpd_pkg::LEN_W-1:0] ONE_LEN = cpd_pkg::LEN_W'(1);

  logic                            active_q;
  logic                            slot_q;
  logic [cpd_pkg::TYPE_W-1:0]      type_q;
  logic [cpd_pkg::LEN_W-1:0]       len_q;
  logic [cpd_pkg::LEN_W-1:0]       k_q;
  logic                            out_valid_q;
  logic [cpd_pkg::TYPE_W-1:0]      out_type_q;
  logic [cpd_pkg::INDEX_W-1:0]     out_idx_q;
  logic                            out_last_q;

  logic                            issue;
  logic                            is_last;
  logic [cpd_pkg::LEN_W-1:0]       k_next;
  logic [cpd_pkg::LEN_W+IDX_W-1:0] k_ext;

  // Read a byte when the result register is free or being taken
  assign issue   = active_q && (!out_valid_q || pop_i);
  assign k_next  = k_q + ONE_LEN;
  assign is_last = (k_next == len_q);
  assign k_ext   = {{IDX_W{1'b0}}, k_q};

  assign re_o       = issue;
  assign raddr_o    = {slot_q, k_ext[IDX_W-1:0]};
  assign desc_pop_o = !active_q && !desc_empty_i;
  assign release_o  = '{valid: issue && is_last, slot: slot_q};

  assign empty_o       = !out_valid_q;
  assign packet_type_o = out_type_q;
  assign byte_index_o  = out_idx_q;
  assign last_o        = out_last_q;

  // Latch descriptor, step through the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      slot_q      <= 1'b0;
      type_q      <= '0;
      len_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (desc_pop_o) begin
        active_q <= 1'b1;
        slot_q   <= desc_i.slot;
        type_q   <= desc_i.ptype;
        len_q    <= desc_i.len;
        k_q      <= '0;
      end else if (issue) begin
        k_q <= k_next;
        if (is_last) begin
          active_q <= 1'b0;
        end
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result side fields travel with the read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_type_q <= type_q;
      out_idx_q  <= k_q[cpd_pkg::INDEX_W-1:0];
      out_last_q <= is_last;
    end
  end

  `CPD_ASSERT(a_index_in_range, active_q |-> (k_q < len_q), "replay index past packet end")

endmodule

`default_nettype wire

[hw/rtl/crc16_packet_deframer.sv]
// ----------------------------------------------------------------------------
// CRC-16 packet deframer
// Hunts for sync 0xFA, decodes the type byte, stores the payload, checks
// CRC-16/CCITT-FALSE and replays good packets byte by byte.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//  bytes in | push_i / full_o      | rx_byte_i
//  results  | pop_i / empty_o      | packet_type_o, byte_index_o,
//           |                      | payload_byte_o, last_o
//
//  One received byte is taken per cycle while full_o is low. A good packet
//  passes through the replay queue, the replay-side descriptor latch and the
//  RAM read register to the result side, one payload byte per cycle while the
//  receiver pops. Two buffer slots alternate; full_o rises on a payload byte
//  only while its slot holds a packet queued for or under replay. Reset
//  clears control state only; the payload RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_deframer_defines.svh"

module crc16_packet_deframer #(
  parameter int unsigned PAYLOAD_DEPTH = cpd_pkg::PAYLOAD_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cpd_pkg::REG_W-1:0]   cfg_idx_i,
  input  wire logic [cpd_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  wire logic                        push_i,
  input  wire logic [cpd_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                             full_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [cpd_pkg::TYPE_W-1:0]       packet_type_o,
  output logic [cpd_pkg::INDEX_W-1:0]      byte_index_o,
  output logic [cpd_pkg::BYTE_W-1:0]       payload_byte_o,
  output logic                             last_o
);

  localparam int unsigned IDX_W     = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned RAM_DEPTH = 2 ** (IDX_W + 1);

  logic                       we;
  logic [IDX_W:0]             waddr;
  logic [cpd_pkg::BYTE_W-1:0] wdata;
  logic                       re;
  logic [IDX_W:0]             raddr;
  logic                       desc_push;
  logic                       desc_pop;
  logic                       desc_full;
  logic                       desc_empty;
  cpd_pkg::desc_t             desc_in;
  cpd_pkg::desc_t             desc_out;
  cpd_pkg::release_t          rel;

  // Parse, store and check
  cpd_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .push_i,
    .rx_byte_i,
    .full_o,
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .desc_push_o(desc_push),
    .desc_o     (desc_in),
    .release_i  (rel)
  );

  // Good packets waiting for replay
  cpd_desc_fifo u_desc_fifo (
    .clk_i,
    .rst_ni,
    .push_i (desc_push),
    .data_i (desc_in),
    .full_o (desc_full),
    .pop_i  (desc_pop),
    .data_o (desc_out),
    .empty_o(desc_empty)
  );

  // Two payload slots
  cpd_ram #(
    .WIDTH(cpd_pkg::BYTE_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(payload_byte_o)
  );

  // Replay good packets
  cpd_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .desc_empty_i (desc_empty),
    .desc_i       (desc_out),
    .desc_pop_o   (desc_pop),
    .release_o    (rel),
    .re_o         (re),
    .raddr_o      (raddr),
    .pop_i,
    .empty_o,
    .packet_type_o,
    .byte_index_o,
    .last_o
  );

  // Slot ownership keeps the replay queue from overflowing
  `CPD_ASSERT_NEVER(a_desc_overflow, desc_push && desc_full, "good packet into full replay queue")

endmodule

`default_nettype wire

[bench/tb_crc16_packet_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-16 packet deframer
// Feeds framed byte streams (good, corrupted, truncated and noise) through
// the queue-style input, predicts every replayed payload byte with a local
// parser and CRC-16/CCITT-FALSE checker, and compares each popped result.
// ----------------------------------------------------------------------------
module tb_crc16_packet_deframer;
  import cpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600_000;
  localparam int          RANDOM_ITEMS = 310;
  localparam int          SETTLE_CYCLES = 12;
  localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(PAYLOAD_DEPTH_DEF);

  typedef enum logic [2:0] {ST_HUNT, ST_TYPE, ST_DATA, ST_CRC_LO, ST_CRC_HI} parse_e;
  typedef enum logic [2:0] {ROW_CFG, ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD} row_e;

  typedef struct packed {
    logic [TYPE_W-1:0]  ptype;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } result_t;

  // want_n < 0: take the prediction; otherwise the typed-in count (0 or 1)
  typedef struct {
    row_e              kind;
    logic [REG_W-1:0]  idx;
    logic [BYTE_W-1:0] val;
    int                want_n;
    logic [TYPE_W-1:0] want_type;
    logic [BYTE_W-1:0] want_byte;
  } step_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [REG_W-1:0]    cfg_idx_i;
  logic [LEN_W-1:0]    cfg_wdata_i;
  logic                push_i;
  logic [BYTE_W-1:0]   rx_byte_i;
  logic                full_o;
  logic                pop_i;
  logic                empty_o;
  logic [TYPE_W-1:0]   packet_type_o;
  logic [INDEX_W-1:0]  byte_index_o;
  logic [BYTE_W-1:0]   payload_byte_o;
  logic                last_o;

  // Parser copy and its registers
  parse_e            stage;
  logic [TYPE_W-1:0] cur_type;
  logic [LEN_W-1:0]  pay_cnt;
  logic [LEN_W-1:0]  pkt_len;
  logic [BYTE_W-1:0] pay_buf [0:63];
  logic [CRC_W-1:0]  crc_run;
  logic [BYTE_W-1:0] crc_lo;
  logic [LEN_W-1:0]  len_reg [0:2];

  result_t fresh [0:63];
  result_t replay_q [$];

  int          err_count;
  int          sent_bytes;
  int          burst_left;
  int unsigned cycles;
  logic [15:0] pop_mask;
  logic [3:0]  pop_slot;

  step_row_t plan [0:30] = '{
    '{ROW_CFG,     REG_RAW_LEN, 8'd1,      -1, PKT_RAW, 8'h00},
    '{ROW_CFG,     REG_NAV_LEN, 8'd0,      -1, PKT_RAW, 8'h00},
    '{ROW_CFG,     REG_ACK_LEN, 8'd2,      -1, PKT_RAW, 8'h00},
    '{ROW_CFG,     REG_UNUSED,  8'h7F,     -1, PKT_RAW, 8'h00},
    // noise while hunting, then sync taken as a type byte
    '{ROW_BYTE,    2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    // one-byte raw packet; length rewritten mid-packet must not apply
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, TYPE_RAW_BYTE,     0, PKT_RAW, 8'h00},
    '{ROW_CFG,     REG_RAW_LEN, 8'd127,    -1, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_LO,  2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_HI,  2'd0, 8'h00,             1, PKT_RAW, 8'h00},
    // nav with zero length (clamps to one) carrying a sync byte as payload
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, TYPE_NAV_BYTE,     0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_CRC_LO,  2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_HI,  2'd0, 8'h00,             1, PKT_NAV, SYNC_BYTE},
    // unknown type byte
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, 8'h33,             0, PKT_RAW, 8'h00},
    // two-byte acknowledge
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, TYPE_ACK_BYTE,     0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, 8'hFF,             0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, 8'h01,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_LO,  2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_HI,  2'd0, 8'h00,            -1, PKT_RAW, 8'h00},
    // bad CRC drops the packet
    '{ROW_BYTE,    2'd0, SYNC_BYTE,         0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, TYPE_NAV_BYTE,     0, PKT_RAW, 8'h00},
    '{ROW_BYTE,    2'd0, 8'hFF,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_LO,  2'd0, 8'h00,             0, PKT_RAW, 8'h00},
    '{ROW_CRC_BAD, 2'd0, 8'h00,             0, PKT_RAW, 8'h00}
  };

  crc16_packet_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push_i),
    .rx_byte_i      (rx_byte_i),
    .full_o         (full_o),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .packet_type_o  (packet_type_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Fold one byte into the CRC one bit at a time, MSB first
  function automatic logic [CRC_W-1:0] crc16_fold(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] d);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c = {c[CRC_W-2:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Saturate a length register to the usable buffer range
  function automatic logic [LEN_W-1:0] fit_len(logic [LEN_W-1:0] v);
    if (v == '0) return 7'd1;
    if (v > BUF_LEN) return BUF_LEN;
    return v;
  endfunction

  // Advance the parser by one byte; fill fresh[] with the replayed payload
  function automatic int deframe_byte(logic [BYTE_W-1:0] b);
    int n;
    n = 0;
    case (stage)
      ST_HUNT: begin
        if (b == SYNC_BYTE) stage = ST_TYPE;
      end
      ST_TYPE: begin
        if (b == TYPE_RAW_BYTE || b == TYPE_NAV_BYTE || b == TYPE_ACK_BYTE) begin
          cur_type = (b == TYPE_RAW_BYTE) ? PKT_RAW :
                     (b == TYPE_NAV_BYTE) ? PKT_NAV : PKT_ACK;
          pkt_len = fit_len(len_reg[cur_type]);
          pay_cnt = '0;
          crc_run = CRC_INIT;
          stage = ST_DATA;
        end else begin
          stage = ST_HUNT;
        end
      end
      ST_DATA: begin
        pay_buf[pay_cnt[5:0]] = b;
        crc_run = crc16_fold(crc_run, b);
        pay_cnt = pay_cnt + 7'd1;
        if (pay_cnt >= pkt_len) stage = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        crc_lo = b;
        stage = ST_CRC_HI;
      end
      default: begin
        stage = ST_HUNT;
        if ({b, crc_lo} == crc_run) begin
          for (int k = 0; k < int'(pkt_len); k++) begin
            fresh[k].ptype = cur_type;
            fresh[k].idx   = INDEX_W'(k);
            fresh[k].data  = pay_buf[k];
            fresh[k].last  = (k + 1 == int'(pkt_len));
          end
          n = int'(pkt_len);
        end
      end
    endcase
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] type_byte(logic [TYPE_W-1:0] t);
    case (t)
      PKT_RAW: return TYPE_RAW_BYTE;
      PKT_NAV: return TYPE_NAV_BYTE;
      default: return TYPE_ACK_BYTE;
    endcase
  endfunction

  // Payload content leaning on sync and the byte extremes
  function automatic logic [BYTE_W-1:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return SYNC_BYTE;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] extreme_len(int i);
    case (i)
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return BUF_LEN;
      default: return 7'd127;
    endcase
  endfunction

  // Early phases walk every register through the extremes
  function automatic logic [LEN_W-1:0] pick_len(int ph, int r);
    if (ph < 4) return extreme_len((ph + r) % 4);
    if ($urandom_range(0, 4) == 0) return extreme_len($urandom_range(0, 3));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (err_count < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Hold until every predicted byte has been popped, then let the block settle
  task automatic wait_drained();
    while (replay_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [LEN_W-1:0] val);
    push_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= REG_ACK_LEN) len_reg[idx] = val;
  endtask

  // Push one byte in bursts with random gaps; queue what it should release
  task automatic send_byte(input logic [BYTE_W-1:0] b, input int want_n,
                           input result_t want_r);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push_i    <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full_o);
    sent_bytes++;
    n = deframe_byte(b);
    if (want_n < 0) begin
      for (int k = 0; k < n; k++) replay_q.push_back(fresh[k]);
    end else if (want_n == 1) begin
      replay_q.push_back(want_r);
    end
  endtask

  // One well-formed frame with random content; a few carry a flipped CRC bit
  task automatic send_frame();
    logic [TYPE_W-1:0] t;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  sum;
    // finish off whatever the parser is still holding
    while (stage != ST_HUNT) send_byte(rand_payload(), -1, '0);
    t = TYPE_W'($urandom_range(PKT_RAW, PKT_ACK));
    if (fit_len(len_reg[t]) > 7'd16 && $urandom_range(0, 7) != 0) begin
      for (int j = PKT_RAW; j <= PKT_ACK; j++)
        if (fit_len(len_reg[j]) < fit_len(len_reg[t])) t = TYPE_W'(j);
    end
    len = fit_len(len_reg[t]);
    send_byte(SYNC_BYTE, -1, '0);
    send_byte(type_byte(t), -1, '0);
    repeat (len) send_byte(rand_payload(), -1, '0);
    sum = crc_run;
    if ($urandom_range(0, 9) == 0) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    send_byte(sum[7:0], -1, '0);
    send_byte(sum[15:8], -1, '0);
  endtask

  // Truncated or mistyped frame start
  task automatic send_broken();
    send_byte(SYNC_BYTE, -1, '0);
    if ($urandom_range(0, 2) == 0) send_byte(BYTE_W'($urandom_range(0, 255)), -1, '0);
    else send_byte(type_byte(TYPE_W'($urandom_range(PKT_RAW, PKT_ACK))), -1, '0);
    repeat ($urandom_range(0, 4)) send_byte(rand_payload(), -1, '0);
  endtask

  // Receiver stalls follow a 16-bit pop mask, redrawn each time its slot counter wraps
  always @(posedge clk_i) begin
    if (pop_slot == 4'd0) begin
      case ($urandom_range(0, 3))
        0:       pop_mask = 16'hFFFF;
        1:       pop_mask = 16'h8001;
        default: pop_mask = 16'($urandom);
      endcase
    end
    pop_i    <= pop_mask[pop_slot];
    pop_slot <= pop_slot + 4'd1;
  end

  // Compare each popped transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t head;
    if (rst_ni && pop_i && !empty_o) begin
      if (replay_q.size() == 0) begin
        flag_mismatch("result with none pending, payload_byte", payload_byte_o, 0);
      end else begin
        head = replay_q.pop_front();
        if (packet_type_o !== head.ptype)
          flag_mismatch("packet_type", packet_type_o, head.ptype);
        if (byte_index_o !== head.idx)
          flag_mismatch("byte_index", byte_index_o, head.idx);
        if (payload_byte_o !== head.data)
          flag_mismatch("payload_byte", payload_byte_o, head.data);
        if (last_o !== head.last)
          flag_mismatch("last", last_o, head.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    step_row_t row;
    result_t   want;
    int        rand_start;
    int        phase_id;
    int        pick;

    cycles      = 0;
    err_count   = 0;
    sent_bytes  = 0;
    burst_left  = 0;
    pop_mask    = 16'hFFFF;
    pop_slot    = 4'd0;
    stage       = ST_HUNT;
    cur_type    = PKT_RAW;
    pay_cnt     = '0;
    pkt_len     = '0;
    crc_run     = CRC_INIT;
    crc_lo      = '0;
    len_reg[REG_RAW_LEN] = RAW_LEN_RST;
    len_reg[REG_NAV_LEN] = NAV_LEN_RST;
    len_reg[REG_ACK_LEN] = ACK_LEN_RST;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_RAW_LEN;
    cfg_wdata_i = '0;
    push_i      = 1'b0;
    rx_byte_i   = '0;
    pop_i       = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < 31; i++) begin
      row = plan[i];
      want.ptype = row.want_type;
      want.idx   = '0;
      want.data  = row.want_byte;
      want.last  = 1'b1;
      case (row.kind)
        ROW_CFG:    write_reg(row.idx, row.val[LEN_W-1:0]);
        ROW_BYTE:   send_byte(row.val, row.want_n, want);
        ROW_CRC_LO: send_byte(crc_run[7:0], row.want_n, want);
        ROW_CRC_HI: send_byte(crc_run[15:8], row.want_n, want);
        default:    send_byte(crc_run[15:8] ^ 8'h5A, row.want_n, want);
      endcase
    end

    // Random phases, each under a fresh register setting
    rand_start = sent_bytes;
    phase_id = 0;
    while (sent_bytes - rand_start < RANDOM_ITEMS) begin
      write_reg(REG_RAW_LEN, pick_len(phase_id, 0));
      write_reg(REG_NAV_LEN, pick_len(phase_id, 1));
      write_reg(REG_ACK_LEN, pick_len(phase_id, 2));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, LEN_W'($urandom_range(0, 127)));
      repeat ($urandom_range(3, 6)) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) send_frame();
        else if (pick == 8) repeat ($urandom_range(1, 3))
          send_byte(BYTE_W'($urandom_range(0, 255)), -1, '0);
        else send_broken();
      end
      phase_id++;
    end

    push_i <= 1'b0;
    wait_drained();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[crc16_packet_deframer.f]
+incdir+hw/rtl
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_ram.sv
hw/rtl/cpd_front.sv
hw/rtl/cpd_desc_fifo.sv
hw/rtl/cpd_back.sv
hw/rtl/crc16_packet_deframer.sv
bench/tb_crc16_packet_deframer.sv
